FILE: rtl/tpa_pkg.sv
// Shared widths for the triangle perimeter and area pipeline.
package tpa_pkg;

  // Result field widths.
  localparam int PERIM_W = 23;
  localparam int AREA_W  = 33;

  // Number of root steps done by each square-root stage.
  localparam int ROOT_STEPS = 4;

  // Side lengths carry four fraction bits, so the squared length is scaled by 2^8.
  localparam int SQ_SHIFT = 8;

endpackage

FILE: rtl/tpa_if.sv
// Channel interfaces: vertex words in, perimeter and area words out.
interface tpa_in_if #(
  parameter int CW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] ax;
  logic signed [CW-1:0] ay;
  logic signed [CW-1:0] bx;
  logic signed [CW-1:0] by_coord;
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;

  modport source (output valid, ax, ay, bx, by_coord, cx, cy, input ready);
  modport sink   (input valid, ax, ay, bx, by_coord, cx, cy, output ready);
endinterface

interface tpa_out_if;
  logic                         valid;
  logic                         ready;
  logic [tpa_pkg::PERIM_W-1:0]  perimeter;
  logic [tpa_pkg::AREA_W-1:0]   twice_area;

  modport source (output valid, perimeter, twice_area, input ready);
  modport sink   (input valid, perimeter, twice_area, output ready);
endinterface

FILE: rtl/triangle_perimeter_area.sv
// Top level of the triangle perimeter and doubled-area pipeline.
//
// Usage: one word on req carries the three vertices (ax, ay, bx, by_coord,
// cx, cy) as signed COORD_WIDTH-bit integers. One word on rsp answers it,
// in order, with the perimeter (sum of the three side lengths, each floored
// to sixteenths of a unit) and twice the area (the exact absolute cross
// product). Both channels use valid/ready; a word moves when both are high.
//
// From accept to rsp.valid a word passes three front stages (differences,
// multipliers, sums), one square-root stage per four root digits, and the
// output register. The pipeline takes one triangle per cycle while rsp is
// not stalled.
//
// Each stage has its own valid bit and advances when empty or when the next
// stage takes its word, so gaps close up under a stall and req stays ready
// until every stage is full. A stall on rsp holds the output word steady.
// Reset clears all valid bits; no word is in flight afterward.
module triangle_perimeter_area #(
  parameter int COORD_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  tpa_in_if.sink    req,
  tpa_out_if.source rsp
);

  localparam int NS = (COORD_WIDTH + 8) / tpa_pkg::ROOT_STEPS;
  localparam int N  = NS * tpa_pkg::ROOT_STEPS;

  logic                          f_valid, f_ready;
  logic [2:0][2*COORD_WIDTH:0]   f_sq;
  logic [tpa_pkg::AREA_W-1:0]    f_area;

  logic                          s_valid [NS+1];
  logic                          s_ready [NS+1];
  logic [2:0][2*N-1:0]           s_val   [NS+1];
  logic [2:0][N+1:0]             s_rem   [NS+1];
  logic [2:0][N-1:0]             s_root  [NS+1];
  logic [tpa_pkg::AREA_W-1:0]    s_area  [NS+1];

  // Differences, products and squared side lengths.
  tpa_front #(.CW(COORD_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .sq_sum    (f_sq),
    .area      (f_area)
  );

  // Feed the root pipeline with each squared length scaled by 2^8.
  always_comb begin
    s_valid[0] = f_valid;
    f_ready    = s_ready[0];
    s_area[0]  = f_area;
    for (int l = 0; l < 3; l++) begin
      s_val[0][l]  = (2*N)'({f_sq[l], {tpa_pkg::SQ_SHIFT{1'b0}}});
      s_rem[0][l]  = '0;
      s_root[0][l] = '0;
    end
  end

  // Square-root stages.
  for (genvar g = 0; g < NS; g++) begin : g_root
    tpa_sqrt_stage #(.N(N)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (s_valid[g]),
      .in_ready  (s_ready[g]),
      .in_val    (s_val[g]),
      .in_rem    (s_rem[g]),
      .in_root   (s_root[g]),
      .in_area   (s_area[g]),
      .out_valid (s_valid[g+1]),
      .out_ready (s_ready[g+1]),
      .out_val   (s_val[g+1]),
      .out_rem   (s_rem[g+1]),
      .out_root  (s_root[g+1]),
      .out_area  (s_area[g+1])
    );
  end

  // Perimeter sum and output register.
  tpa_tail #(.N(N)) u_tail (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_valid[NS]),
    .in_ready (s_ready[NS]),
    .in_root  (s_root[NS]),
    .in_area  (s_area[NS]),
    .rsp      (rsp)
  );

  // A ready receiver lets every stage advance, so the input must be ready.
  assert property (@(posedge clk) disable iff (rst) rsp.ready |-> req.ready)
    else $error("input not ready while output is drained");

  // Reset empties the pipeline.
  assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("output valid right after reset");

  // A word held in the last root stage stays put while the tail is stalled.
  assert property (@(posedge clk) disable iff (rst)
    s_valid[NS] && !s_ready[NS] |=> s_valid[NS] && $stable(s_root[NS]))
    else $error("root stage lost its word under a stall");

endmodule

FILE: rtl/tpa_front.sv
// Front end: coordinate differences, squares and cross products, sums and area.
module tpa_front #(
  parameter int CW = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  tpa_in_if.sink                        req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0][2*CW:0]            sq_sum,
  output logic [tpa_pkg::AREA_W-1:0]    area
);

  // Stage one: edge vectors AB, BC and AC.
  logic                 v1;
  logic signed [CW:0]   xab, yab, xbc, ybc, xca, yca;
  // Stage two: squares and cross terms.
  logic                 v2;
  logic [2*CW-1:0]      sqx_ab, sqy_ab, sqx_bc, sqy_bc, sqx_ca, sqy_ca;
  logic signed [2*CW+1:0] cr1, cr2;
  // Stage three: squared side lengths and area magnitude.
  logic                 v3;

  logic a1, a2, a3;
  logic signed [2*CW+1:0] p_xab, p_yab, p_xbc, p_ybc, p_xca, p_yca, p_c1, p_c2;
  logic signed [2*CW+2:0] xprod;
  logic [2*CW+2:0]        mag;

  // Each stage moves when it is empty or the next one takes its word.
  assign a3 = !v3 || out_ready;
  assign a2 = !v2 || a3;
  assign a1 = !v1 || a2;
  assign req.ready = a1;
  assign out_valid = v3;

  // Full products of the edge vectors.
  assign p_xab = xab * xab;
  assign p_yab = yab * yab;
  assign p_xbc = xbc * xbc;
  assign p_ybc = ybc * ybc;
  assign p_xca = xca * xca;
  assign p_yca = yca * yca;
  assign p_c1  = xab * yca;
  assign p_c2  = yab * xca;

  // Signed cross product and its magnitude.
  assign xprod = (2*CW+3)'(cr1) - (2*CW+3)'(cr2);
  assign mag   = xprod[2*CW+2] ? unsigned'(-xprod) : unsigned'(xprod);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (a1) v1 <= req.valid;
      if (a2) v2 <= v1;
      if (a3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (a1) begin
      xab <= (CW+1)'(req.bx) - (CW+1)'(req.ax);
      yab <= (CW+1)'(req.by_coord) - (CW+1)'(req.ay);
      xbc <= (CW+1)'(req.cx) - (CW+1)'(req.bx);
      ybc <= (CW+1)'(req.cy) - (CW+1)'(req.by_coord);
      xca <= (CW+1)'(req.cx) - (CW+1)'(req.ax);
      yca <= (CW+1)'(req.cy) - (CW+1)'(req.ay);
    end
    if (a2) begin
      sqx_ab <= p_xab[2*CW-1:0];
      sqy_ab <= p_yab[2*CW-1:0];
      sqx_bc <= p_xbc[2*CW-1:0];
      sqy_bc <= p_ybc[2*CW-1:0];
      sqx_ca <= p_xca[2*CW-1:0];
      sqy_ca <= p_yca[2*CW-1:0];
      cr1    <= p_c1;
      cr2    <= p_c2;
    end
    if (a3) begin
      sq_sum[0] <= {1'b0, sqx_ab} + {1'b0, sqy_ab};
      sq_sum[1] <= {1'b0, sqx_bc} + {1'b0, sqy_bc};
      sq_sum[2] <= {1'b0, sqx_ca} + {1'b0, sqy_ca};
      area      <= tpa_pkg::AREA_W'(mag);
    end
  end

endmodule

FILE: rtl/tpa_sqrt_stage.sv
// One stage of the pipelined square root: a few digit steps on three sides.
module tpa_sqrt_stage #(
  parameter int N = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0][2*N-1:0]           in_val,
  input  logic [2:0][N+1:0]             in_rem,
  input  logic [2:0][N-1:0]             in_root,
  input  logic [tpa_pkg::AREA_W-1:0]    in_area,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0][2*N-1:0]           out_val,
  output logic [2:0][N+1:0]             out_rem,
  output logic [2:0][N-1:0]             out_root,
  output logic [tpa_pkg::AREA_W-1:0]    out_area
);

  logic                 v;
  logic [2:0][2*N-1:0]  val_next;
  logic [2:0][N+1:0]    rem_next;
  logic [2:0][N-1:0]    root_next;

  assign in_ready  = !v || out_ready;
  assign out_valid = v;

  // Restoring digit steps: bring in two value bits, try root*4+1.
  always_comb begin
    logic [2*N-1:0] vv;
    logic [N+1:0]   rr;
    logic [N-1:0]   qq;
    logic [N+3:0]   t;
    logic [N+3:0]   trial;
    for (int l = 0; l < 3; l++) begin
      vv = in_val[l];
      rr = in_rem[l];
      qq = in_root[l];
      for (int s = 0; s < tpa_pkg::ROOT_STEPS; s++) begin
        t     = {rr, vv[2*N-1:2*N-2]};
        vv    = {vv[2*N-3:0], 2'b00};
        trial = {2'b00, qq, 2'b01};
        if (t >= trial) begin
          t  = t - trial;
          qq = {qq[N-2:0], 1'b1};
        end else begin
          qq = {qq[N-2:0], 1'b0};
        end
        rr = t[N+1:0];
      end
      val_next[l]  = vv;
      rem_next[l]  = rr;
      root_next[l] = qq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_val  <= val_next;
      out_rem  <= rem_next;
      out_root <= root_next;
      out_area <= in_area;
    end
  end

endmodule

FILE: rtl/tpa_tail.sv
// Output stage: adds the three side lengths and holds the result word.
module tpa_tail #(
  parameter int N = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0][N-1:0]             in_root,
  input  logic [tpa_pkg::AREA_W-1:0]    in_area,
  tpa_out_if.source                     rsp
);

  logic         v;
  logic [N+1:0] per_sum;

  assign in_ready  = !v || rsp.ready;
  assign rsp.valid = v;
  assign per_sum   = (N+2)'(in_root[0]) + (N+2)'(in_root[1]) + (N+2)'(in_root[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (in_ready) begin
      v <= in_valid;
    end
  end

  // The perimeter wraps to its field width.
  always_ff @(posedge clk) begin
    if (in_ready) begin
      rsp.perimeter  <= tpa_pkg::PERIM_W'(per_sum);
      rsp.twice_area <= in_area;
    end
  end

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the triangle perimeter and doubled-area pipeline.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 16;
  localparam int RANDOM_WORDS = 1150;

  typedef struct {
    logic signed [CW-1:0] ax, ay, bx, by_coord, cx, cy;
  } tri_t;

  typedef struct {
    logic [tpa_pkg::PERIM_W-1:0] perimeter;
    logic [tpa_pkg::AREA_W-1:0]  twice_area;
  } meas_t;

  // Directed row: vertices, plus a typed-in answer where one is obvious.
  typedef struct {
    tri_t  t;
    bit    known;
    meas_t m;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors = 0;
  int   phase = 0;
  bit   hold_off = 1'b0;
  bit   drive_done = 1'b0;
  meas_t pending_meas[$];

  tpa_in_if #(.CW(CW)) req ();
  tpa_out_if rsp ();

  triangle_perimeter_area #(.COORD_WIDTH(CW)) uut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Integer square root, floored, by the bitwise digit method.
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Side length in sixteenths of a coordinate unit.
  function automatic longint unsigned side_sixteenths(longint x0, longint y0,
                                                      longint x1, longint y1);
    longint dx, dy;
    dx = x1 - x0;
    dy = y1 - y0;
    return root_floor((dx * dx + dy * dy) * 256);
  endfunction

  // Expected perimeter and doubled area of one triangle.
  function automatic meas_t measure_triangle(tri_t t);
    meas_t m;
    longint xa, ya, xb, yb, xc, yc, xprod;
    longint unsigned per;
    xa = longint'(t.ax); ya = longint'(t.ay); xb = longint'(t.bx);
    yb = longint'(t.by_coord); xc = longint'(t.cx); yc = longint'(t.cy);
    per = side_sixteenths(xa, ya, xb, yb) + side_sixteenths(xb, yb, xc, yc)
        + side_sixteenths(xc, yc, xa, ya);
    xprod = (xb - xa) * (yc - ya) - (yb - ya) * (xc - xa);
    if (xprod < 0) xprod = -xprod;
    m.perimeter = per[tpa_pkg::PERIM_W-1:0];
    m.twice_area = xprod[tpa_pkg::AREA_W-1:0];
    return m;
  endfunction

  function automatic tri_t mk(int a, int b, int c, int d, int e, int f);
    tri_t t;
    t.ax = CW'(a); t.ay = CW'(b); t.bx = CW'(c);
    t.by_coord = CW'(d); t.cx = CW'(e); t.cy = CW'(f);
    return t;
  endfunction

  function automatic tri_t random_triangle();
    tri_t t;
    int base;
    case ($urandom_range(3))
      0: begin
        t = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      1: begin
        // Small triangle clustered near a random point.
        base = $urandom_range(65535) - 32768;
        t = mk(base, base, base + $urandom_range(40) - 20, base + $urandom_range(40) - 20,
               base + $urandom_range(40) - 20, base - $urandom_range(20));
      end
      2: begin
        // Vertices A and B drawn from the extremes of the range, C at random.
        t = mk($urandom_range(1) ? 32767 : -32768, $urandom_range(1) ? 32767 : -32768,
               $urandom_range(1) ? 32767 : -32768, $urandom_range(1) ? 32767 : -32768,
               $urandom, $urandom);
      end
      default: begin
        // Collinear points along the line y = 2x, at a random scale.
        base = $urandom_range(200) - 100;
        t = mk(0, 0, base, 2 * base, 3 * base, 6 * base);
      end
    endcase
    return t;
  endfunction

  // Offer one word and wait until it is taken, idling as the phase asks.
  // Valid stays high between words that follow with no idle cycle.
  task automatic send_word(tri_t t);
    int idle_pct;
    idle_pct = (phase == 0) ? 17 : (phase == 1) ? 86 : 0;
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.ax <= t.ax; req.ay <= t.ay; req.bx <= t.bx;
    req.by_coord <= t.by_coord; req.cx <= t.cx; req.cy <= t.cy;
    req.valid <= 1'b1;
    pending_meas.push_back(measure_triangle(t));
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stimulus: directed table, then three random phases.
  initial begin
    row_t rows[$];
    row_t r;
    tri_t t;
    meas_t pm;
    req.valid = 1'b0;
    req.ax = '0; req.ay = '0; req.bx = '0;
    req.by_coord = '0; req.cx = '0; req.cy = '0;
    r.known = 1'b1;
    r.t = mk(0, 0, 0, 0, 0, 0);
    r.m = '{tpa_pkg::PERIM_W'(0), tpa_pkg::AREA_W'(0)}; rows.push_back(r);
    r.t = mk(0, 0, 1, 0, 0, 1);
    r.m = '{tpa_pkg::PERIM_W'(16 + 16 + 22), tpa_pkg::AREA_W'(1)}; rows.push_back(r);
    r.t = mk(0, 0, 3, 0, 0, 4);
    r.m = '{tpa_pkg::PERIM_W'(48 + 80 + 64), tpa_pkg::AREA_W'(12)}; rows.push_back(r);
    r.t = mk(5, 5, 5, 5, 5, 5);
    r.m = '{tpa_pkg::PERIM_W'(0), tpa_pkg::AREA_W'(0)}; rows.push_back(r);
    r.known = 1'b0;
    r.t = mk(-32768, -32768, 32767, 32767, -32768, 32767); rows.push_back(r);
    r.t = mk(32767, -32768, -32768, 32767, 32767, 32767); rows.push_back(r);
    r.t = mk(-32768, -32768, 32767, -32768, 32767, 32767); rows.push_back(r);
    r.t = mk(-32768, -32768, 32767, 32767, 0, 0); rows.push_back(r);
    r.t = mk(1, 2, 3, 4, 5, 6); rows.push_back(r);
    r.t = mk(-1, -1, -1, -1, 100, -7); rows.push_back(r);
    r.t = mk(32767, 32767, 32767, 32767, -32768, -32768); rows.push_back(r);
    r.t = mk(-21846, 21845, 21845, -21846, 1, 1); rows.push_back(r);
    r.t = mk(0, -32768, 0, 32767, 0, 0); rows.push_back(r);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[i]) begin
      pm = measure_triangle(rows[i].t);
      if (rows[i].known && (pm.perimeter != rows[i].m.perimeter ||
                            pm.twice_area != rows[i].m.twice_area)) begin
        $display("%0t table row %0d: expected %0d/%0d, predictor %0d/%0d", $time, i,
                 rows[i].m.perimeter, rows[i].m.twice_area,
                 pm.perimeter, pm.twice_area);
        errors++;
      end
      send_word(rows[i].t);
    end
    for (int p = 0; p < 3; p++) begin
      phase = p;
      if (p == 2) hold_off = 1'b1;
      for (int n = 0; n < RANDOM_WORDS / 3; n++) begin
        t = random_triangle();
        send_word(t);
      end
    end
    req.valid <= 1'b0;
    drive_done = 1'b1;
  end

  // Receiver: random stalls per phase, plus one long hold-off.
  initial begin
    rsp.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        rsp.ready <= 1'b0;
        for (int c = 0; c < 60; c++) @(negedge clk);
        hold_off = 1'b0;
      end else begin
        case (phase)
          0: rsp.ready <= ($urandom_range(99) >= 86);
          1: rsp.ready <= ($urandom_range(99) >= 17);
          default: rsp.ready <= 1'b1;
        endcase
        @(negedge clk);
      end
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    meas_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_meas.size() == 0) begin
        $display("%0t unexpected word: perimeter %0d area %0d", $time,
                 rsp.perimeter, rsp.twice_area);
        errors++;
      end else begin
        want = pending_meas.pop_front();
        if (rsp.perimeter !== want.perimeter) begin
          $display("%0t perimeter: expected %0d, actual %0d", $time,
                   want.perimeter, rsp.perimeter);
          errors++;
        end
        if (rsp.twice_area !== want.twice_area) begin
          $display("%0t twice_area: expected %0d, actual %0d", $time,
                   want.twice_area, rsp.twice_area);
          errors++;
        end
      end
    end
  end

  // Drain, then report.
  initial begin
    wait (drive_done);
    while (pending_meas.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tpa_pkg.sv
rtl/tpa_if.sv
rtl/tpa_front.sv
rtl/tpa_sqrt_stage.sv
rtl/tpa_tail.sv
rtl/triangle_perimeter_area.sv
bench/tb.sv
